@@ rtl/ers_pkg.sv @@
// ers_pkg: shared types for the enumeration rank sort unit.
// Holds the controller state type and the command/status structs.
// No dependencies.
package ers_pkg;

	// Controller states
	typedef enum logic [1:0] {
		ST_LOAD  = 2'd0,
		ST_RANK  = 2'd1,
		ST_PLACE = 2'd2,
		ST_EMIT  = 2'd3
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // take the word on value_in into the next cell
		logic rank;   // write the rank of the newest cell
		logic place;  // copy one cell into the sorted memory at its rank
		logic emit;   // read one sorted entry out
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic set_end;   // the word just loaded closes the set
		logic last_idx;  // walk index points at the last loaded cell
	} status_t;

endpackage

@@ rtl/ers_ctrl.sv @@
// ers_ctrl: controller state machine of the enumeration rank sort unit.
// Sequences load, rank, place and emit phases of the datapath.
// Depends on ers_pkg.
module ers_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ers_pkg::status_t status,
	output ers_pkg::cmd_t    cmd,
	output logic            busy
);

	ers_pkg::state_t state_q;
	ers_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ers_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ers_pkg::ST_LOAD: begin
				if (start) state_d = ers_pkg::ST_RANK;
			end
			ers_pkg::ST_RANK: begin
				state_d = status.set_end ? ers_pkg::ST_PLACE : ers_pkg::ST_LOAD;
			end
			ers_pkg::ST_PLACE: begin
				if (status.last_idx) state_d = ers_pkg::ST_EMIT;
			end
			ers_pkg::ST_EMIT: begin
				if (status.last_idx) state_d = ers_pkg::ST_LOAD;
			end
			default: state_d = ers_pkg::ST_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ers_pkg::ST_LOAD: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ers_pkg::ST_RANK:  cmd.rank  = 1'b1;
			ers_pkg::ST_PLACE: cmd.place = 1'b1;
			ers_pkg::ST_EMIT:  cmd.emit  = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/ers_datapath.sv @@
// ers_datapath: cell row, rank logic, sorted memory and output register.
// Each cell holds a loaded word and its running rank; ranks update as words arrive.
// Depends on ers_pkg.
module ers_datapath #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ers_pkg::cmd_t       cmd,
	input  logic signed [31:0]  value_in,
	input  logic                last_in,
	output ers_pkg::status_t    status,
	output logic                valid,
	output logic signed [31:0]  value_out,
	output logic                last_out
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	// Cell row
	logic signed [31:0] val_q  [MAX_ITEMS];
	logic [IDX_W-1:0]   rank_q [MAX_ITEMS];

	// Sorted memory
	logic signed [31:0] sorted_mem [MAX_ITEMS];

	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     idx_q;
	logic [MAX_ITEMS-1:0] le_s1;
	logic [IDX_W-1:0]     pos_s1;
	logic                 end_s1;
	logic                 valid_s1;
	logic [CNT_W-1:0]     rank_sum;
	logic                 last_idx;

	// Walk index reaches the last loaded cell
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	assign status.set_end  = end_s1;
	assign status.last_idx = last_idx;
	assign valid           = valid_s1;

	// Count earlier cells not above the new word
	always_comb begin
		rank_sum = '0;
		for (int k = 0; k < MAX_ITEMS; k++) begin
			rank_sum = rank_sum + CNT_W'(le_s1[k]);
		end
	end

	// Control registers: fill count, walk index, output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.emit;
			if (cmd.load) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.rank) begin
				idx_q <= '0;
			end else if (cmd.place || cmd.emit) begin
				idx_q <= last_idx ? '0 : idx_q + IDX_W'(1);
			end
			// drop the set once its last word is read out
			if (cmd.emit && last_idx) begin
				count_q <= '0;
			end
		end
	end

	// Load a word, compare it against the filled cells, bump larger cells
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q[count_q[IDX_W-1:0]] <= value_in;
			pos_s1 <= count_q[IDX_W-1:0];
			end_s1 <= last_in || (count_q == CNT_W'(MAX_ITEMS - 1));
			for (int k = 0; k < MAX_ITEMS; k++) begin
				le_s1[k] <= (CNT_W'(k) < count_q) && (val_q[k] <= value_in);
				if ((CNT_W'(k) < count_q) && (value_in < val_q[k])) begin
					rank_q[k] <= rank_q[k] + IDX_W'(1);
				end
			end
		end
		if (cmd.rank) begin
			rank_q[pos_s1] <= rank_sum[IDX_W-1:0];
		end
	end

	// Write the sorted memory at each cell's rank
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			sorted_mem[rank_q[idx_q]] <= val_q[idx_q];
		end
	end

	// Read the sorted memory into the output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_out <= sorted_mem[idx_q];
			last_out  <= last_idx;
		end
	end

endmodule

@@ rtl/enumeration_rank_sort_unit.sv @@
// Stable enumeration sort of signed 32-bit words. A word is taken when start is
// high and busy is low; a set closes on last_in or when MAX_ITEMS words are held.
// Each load is an accept step, then a rank write of the new cell, whose rank
// is a count over a registered compare vector. When a set closes, the cells
// are copied one at a time into the sorted memory through its single write
// port and then read out. Results come out in ascending order back to back
// with valid high, last_out on the final one; the receiver cannot stall, so
// they must be taken as they appear.
// No clearing pass follows reset. Depends on ers_pkg, ers_ctrl, ers_datapath.
module enumeration_rank_sort_unit #(
	parameter int MAX_ITEMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value_in,
	input  logic               last_in,
	output logic               valid,
	output logic signed [31:0] value_out,
	output logic               last_out
);

	ers_pkg::cmd_t    cmd;
	ers_pkg::status_t status;

	// Controller
	ers_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath
	ers_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value_in  (value_in),
		.last_in   (last_in),
		.status    (status),
		.valid     (valid),
		.value_out (value_out),
		.last_out  (last_out)
	);

`ifndef NO_ASSERTIONS
	// An emit read always yields a word on the next cycle
	a_emit_to_valid : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> valid)
		else $error("emit read did not produce a word");

	// An accepted word is always followed by its rank cycle
	a_accept_rank : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> cmd.rank)
		else $error("accepted word not followed by rank write");

	// Words of a set come out on consecutive cycles
	a_burst : assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last_out) |=> valid)
		else $error("gap inside a sorted burst");

	// No word comes directly after the final word of a set
	a_end_burst : assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last_out) |=> !valid)
		else $error("word after final sorted word");
`endif

endmodule
